// ===== hdl/lcrx_pkg.sv =====
// shared types and constants for the crlf line receiver
// no dependencies; imported by the top level, lcrx_ctrl and lcrx_outq

package lcrx_pkg;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	localparam logic [1:0] REQ_BYTE    = 2'd0;
	localparam logic [1:0] REQ_RELEASE = 2'd1;
	localparam logic [1:0] REQ_READ    = 2'd2;
	localparam logic [1:0] REQ_CLEAR   = 2'd3;

	localparam int LEN_W = 9;

	// result word minus the stored byte, which comes from the memory's registered read port in the cycle after acceptance
	typedef struct packed {
		logic             line_done;
		logic             done_buffer;
		logic             byte_dropped;
		logic             lost_flag;
		logic             first_full;
		logic             second_full;
		logic [LEN_W-1:0] first_length;
		logic [LEN_W-1:0] second_length;
		logic             rd_hit;
	} rslt_t;

endpackage

// ===== hdl/pingpong_crlf_line_receiver.sv =====
// top level of the crlf line receiver with two line buffers used in turn
// depends on lcrx_pkg, lcrx_ctrl, lcrx_store, lcrx_outq

// Takes one request word per clock on the input channel while in_stall is low and
// returns exactly one result word per request, in order, via the stage-one and output
// registers. Received bytes (request 0) are written into the active line
// buffer; a 0x0A directly after a 0x0D in the same buffer completes the line,
// marks that buffer full and moves filling to the other buffer. A byte aimed at a
// full buffer is dropped and sets the sticky lost flag; a buffer that reaches
// LINE_DEPTH bytes without a line end restarts at zero and sets the lost flag too.
// Request 1 releases a buffer, request 2 reads a stored byte (and clears the lost
// flag), request 3 clears the lost flag. Sustained rate is one word per cycle when
// the output is not stalled: each request costs at most one memory write or one memory
// read, and all small state lives in flops updated at acceptance. The stage-one
// register waits for the registered read port of the line memory. Input stall rises
// only when both result registers are occupied and the output is stalled. The line
// memory is not cleared at reset; reading a position never written returns garbage.

module pingpong_crlf_line_receiver #(
	parameter int LINE_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	// request channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [7:0] rx_byte,
	input  logic       buffer_select,
	input  logic [7:0] read_index,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic       line_done,
	output logic       done_buffer,
	output logic       byte_dropped,
	output logic       lost_flag,
	output logic       first_full,
	output logic       second_full,
	output logic [8:0] first_length,
	output logic [8:0] second_length,
	output logic [7:0] read_data
);

	import lcrx_pkg::*;

	// buffer offset bits and fill counter width (counter must hold the depth itself)
	localparam int AW = $clog2(LINE_DEPTH);
	localparam int CW = $clog2(LINE_DEPTH + 1);

	logic        acc;
	logic        wr_en, rd_en;
	logic [AW:0] wr_addr, rd_addr;
	logic [7:0]  mem_data;
	rslt_t       res;
	rslt_t       out_word;

	// state update happens in the accept cycle, so back to back requests see
	// each other's effects without forwarding
	lcrx_ctrl #(
		.LINE_DEPTH (LINE_DEPTH),
		.AW         (AW),
		.CW         (CW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.acc           (acc),
		.req_type      (req_type),
		.rx_byte       (rx_byte),
		.buffer_select (buffer_select),
		.read_index    (read_index),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.res           (res)
	);

	// both buffers share one memory: buffer select is the top address bit
	lcrx_store #(
		.AW (AW + 1)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (rx_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (mem_data)
	);

	// two registers deep so one result waiting in the output register does not block the next request
	lcrx_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.acc       (acc),
		.res       (res),
		.mem_data  (mem_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.out_data  (read_data)
	);

	assign line_done     = out_word.line_done;
	assign done_buffer   = out_word.done_buffer;
	assign byte_dropped  = out_word.byte_dropped;
	assign lost_flag     = out_word.lost_flag;
	assign first_full    = out_word.first_full;
	assign second_full   = out_word.second_full;
	assign first_length  = out_word.first_length;
	assign second_length = out_word.second_length;

endmodule

// ===== hdl/lcrx_store.sv =====
// line storage memory: one write port, one read port, registered read data
// depends on nothing but its parameter

module lcrx_store #(
	parameter int AW = 9
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [2**AW];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/lcrx_ctrl.sv =====
// request decode and per-buffer state: fill counts, full marks, cr tracking, lost flag
// depends on lcrx_pkg

module lcrx_ctrl #(
	parameter int LINE_DEPTH = 256,
	parameter int AW         = 8,
	parameter int CW         = 9
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            acc,
	input  logic [1:0]      req_type,
	input  logic [7:0]      rx_byte,
	input  logic            buffer_select,
	input  logic [7:0]      read_index,
	output logic            wr_en,
	output logic [AW:0]     wr_addr,
	output logic            rd_en,
	output logic [AW:0]     rd_addr,
	output lcrx_pkg::rslt_t res
);

	import lcrx_pkg::*;

	logic [CW-1:0] count_q [2];
	logic [CW-1:0] count_n [2];
	logic [1:0]    full_q, full_n;
	logic [1:0]    cr_q, cr_n;
	logic          active_q, active_n;
	logic          lost_q, lost_n;

	logic [CW-1:0] cur_cnt;
	logic [AW-1:0] wr_ptr;
	logic [CW-1:0] cnt_inc;
	logic          idx_ok;
	logic          done, dbuf, drop, hit, wr_req;

	assign cur_cnt = count_q[active_q];
	// a count parked at the depth restarts at the buffer start
	assign wr_ptr  = (32'(cur_cnt) >= LINE_DEPTH) ? '0 : cur_cnt[AW-1:0];
	assign cnt_inc = CW'(wr_ptr) + CW'(1);
	assign idx_ok  = 32'(read_index) < LINE_DEPTH;

	always_comb begin
		count_n  = count_q;
		full_n   = full_q;
		cr_n     = cr_q;
		active_n = active_q;
		lost_n   = lost_q;
		done     = 1'b0;
		dbuf     = 1'b0;
		drop     = 1'b0;
		hit      = 1'b0;
		wr_req   = 1'b0;
		unique case (req_type)
			REQ_BYTE: begin
				if (full_q[active_q]) begin
					drop   = 1'b1;
					lost_n = 1'b1;
				end else begin
					wr_req            = 1'b1;
					count_n[active_q] = cnt_inc;
					if (rx_byte == CHAR_LF && cr_q[active_q]) begin
						full_n[active_q] = 1'b1;
						cr_n[active_q]   = 1'b0;
						active_n         = ~active_q;
						done             = 1'b1;
						dbuf             = active_q;
					end else begin
						cr_n[active_q] = (rx_byte == CHAR_CR);
						if (32'(cnt_inc) >= LINE_DEPTH) begin
							// buffer ran out without a line end
							count_n[active_q] = '0;
							cr_n[active_q]    = 1'b0;
							lost_n            = 1'b1;
						end
					end
				end
			end
			REQ_RELEASE: begin
				full_n[buffer_select]  = 1'b0;
				cr_n[buffer_select]    = 1'b0;
				count_n[buffer_select] = '0;
			end
			REQ_READ: begin
				lost_n = 1'b0;
				hit    = idx_ok;
			end
			REQ_CLEAR: begin
				lost_n = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q[0] <= '0;
			count_q[1] <= '0;
			full_q     <= '0;
			cr_q       <= '0;
			active_q   <= 1'b0;
			lost_q     <= 1'b0;
		end else if (acc) begin
			count_q  <= count_n;
			full_q   <= full_n;
			cr_q     <= cr_n;
			active_q <= active_n;
			lost_q   <= lost_n;
		end
	end

	assign wr_en   = acc && wr_req;
	assign wr_addr = {active_q, wr_ptr};
	assign rd_en   = acc && hit;
	// offset only matters when the index is inside the buffer
	assign rd_addr = {buffer_select, AW'(read_index)};

	assign res.line_done     = done;
	assign res.done_buffer   = dbuf;
	assign res.byte_dropped  = drop;
	assign res.lost_flag     = lost_n;
	assign res.first_full    = full_n[0];
	assign res.second_full   = full_n[1];
	assign res.first_length  = LEN_W'(count_n[0]);
	assign res.second_length = LEN_W'(count_n[1]);
	assign res.rd_hit        = hit;

endmodule

// ===== hdl/lcrx_outq.sv =====
// result pipeline: stage one waits for the memory read, then the output register
// depends on lcrx_pkg

module lcrx_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            acc,
	input  lcrx_pkg::rslt_t res,
	input  logic [7:0]      mem_data,
	output logic            out_valid,
	input  logic            out_stall,
	output lcrx_pkg::rslt_t out_word,
	output logic [7:0]      out_data
);

	import lcrx_pkg::*;

	logic  s1_valid_q, out_valid_q;
	rslt_t res_s1, out_q;
	logic [7:0] out_data_q;
	logic  s1_adv;

	assign s1_adv   = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !s1_adv;
	assign acc      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1 <= res;
		end
		if (s1_adv) begin
			out_q      <= res_s1;
			out_data_q <= res_s1.rd_hit ? mem_data : 8'h00;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;
	assign out_data  = out_data_q;

endmodule

// ===== hdl/lcrx_chk.sv =====
// port-level checks for the crlf line receiver, bound to the top level
// depends on pingpong_crlf_line_receiver ports only

module lcrx_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       line_done,
	input logic       done_buffer,
	input logic       byte_dropped,
	input logic       lost_flag,
	input logic       first_full,
	input logic       second_full,
	input logic [8:0] first_length,
	input logic [8:0] second_length,
	input logic [7:0] read_data
);

	// a completed line leaves its buffer marked full
	a_done_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_done |-> (done_buffer ? second_full : first_full))
		else $error("completed line without full mark");

	// done_buffer only means something with line_done
	a_done_buf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !line_done |-> !done_buffer)
		else $error("done_buffer set without line_done");

	// a dropped byte neither completes a line nor leaves the lost flag clear
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_dropped |-> lost_flag && !line_done)
		else $error("dropped byte inconsistent");

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(first_length)
			&& $stable(second_length) && $stable(read_data) && $stable(lost_flag))
		else $error("stalled result changed");

endmodule

bind pingpong_crlf_line_receiver lcrx_chk u_lcrx_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.line_done     (line_done),
	.done_buffer   (done_buffer),
	.byte_dropped  (byte_dropped),
	.lost_flag     (lost_flag),
	.first_full    (first_full),
	.second_full   (second_full),
	.first_length  (first_length),
	.second_length (second_length),
	.read_data     (read_data)
);
